/* rtl/assert_macros.svh */
// Assertion macros for the top-level file that checks this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define HVD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define HVD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/hvd_pkg.sv */
// Types, constants and tables shared by the haversine distance pipeline.
package hvd_pkg;

  localparam int ANGLE_FRAC_BITS = 22;
  localparam int CW = 34;
  localparam int SQRT_STEPS = 32;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic [30:0] q30_t;
  typedef logic [63:0] sq_t;
  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_RADIUS = 2'd0;
  localparam reg_idx_t REG_ROAD   = 2'd1;
  localparam reg_idx_t REG_NEAR   = 2'd2;

  localparam logic signed [32:0] LAT_LIM   = 33'(90 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [32:0] SPAN      = 33'(360 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [32:0] HALF_SPAN = 33'(180 * (2 ** ANGLE_FRAC_BITS));
  localparam int SH_FULL = ANGLE_FRAC_BITS + 6;
  localparam int SH_HALF = ANGLE_FRAC_BITS + 7;

  localparam logic [30:0] DEG2RAD     = 31'd1199381129;
  localparam q30_t        HALF_PI_Q30 = 31'd1686629713;
  localparam q30_t        Q30_ONE     = 31'd1073741824;
  localparam cw_t         HALF_PI_S   = 34'sd1686629713;
  localparam cw_t         Q30_ONE_S   = 34'sd1073741824;
  localparam cw_t         GAIN_INV    = 34'sd652032874;

  localparam logic [54:0] DIST_ROUND = 55'd262144000;
  localparam int          DIST_SHIFT = 22;
  localparam logic [32:0] DIV125_M   = 33'd4398046511;
  localparam int          DIV_SHIFT  = 39;
  localparam logic [24:0] DIST_MAX   = '1;
  localparam logic [26:0] ROAD_MAX   = '1;

  // atan(2^-k) in Q30 radians
  function automatic cw_t arc(input logic [4:0] k);
    cw_t a;
    case (k)
      5'd0:  a = 34'sh03243F6A8;
      5'd1:  a = 34'sh01DAC6705;
      5'd2:  a = 34'sh00FADBAFC;
      5'd3:  a = 34'sh007F56EA6;
      5'd4:  a = 34'sh003FEAB76;
      5'd5:  a = 34'sh001FFD55B;
      5'd6:  a = 34'sh000FFFAAA;
      5'd7:  a = 34'sh0007FFF55;
      5'd8:  a = 34'sh0003FFFEA;
      5'd9:  a = 34'sh0001FFFFD;
      5'd10: a = 34'sh0000FFFFF;
      5'd11: a = 34'sh00007FFFF;
      5'd12: a = 34'sh00003FFFF;
      5'd13: a = 34'sh00001FFFF;
      5'd14: a = 34'sh00000FFFF;
      5'd15: a = 34'sh000007FFF;
      5'd16: a = 34'sh000003FFF;
      5'd17: a = 34'sh000001FFF;
      5'd18: a = 34'sh000000FFF;
      5'd19: a = 34'sh0000007FF;
      5'd20: a = 34'sh0000003FF;
      5'd21: a = 34'sh0000001FF;
      5'd22: a = 34'sh0000000FF;
      5'd23: a = 34'sh00000007F;
      5'd24: a = 34'sh00000003F;
      5'd25: a = 34'sh00000001F;
      5'd26: a = 34'sh00000000F;
      5'd27: a = 34'sh000000008;
      5'd28: a = 34'sh000000004;
      5'd29: a = 34'sh000000002;
      5'd30: a = 34'sh000000001;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic q30_t clamp_q30(input cw_t v);
    q30_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > Q30_ONE_S) begin
      r = Q30_ONE;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

/* rtl/hvd_front.sv */
// Front end: latitude clamp, longitude wrap and degree to radian scaling.
module hvd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic signed [29:0]   first_lat,
  input  logic signed [30:0]   first_lon,
  input  logic signed [29:0]   second_lat,
  input  logic signed [30:0]   second_lon,
  output logic                 vld_out,
  output hvd_pkg::q30_t        ang [4]
);

  logic signed [32:0] la, lb, dlat, diff, t1, dm;
  logic [29:0]        mag_nxt [4];
  logic [29:0]        mag_r [4];
  logic [60:0]        prod_r [4];
  hvd_pkg::q30_t      ang_r [4];
  logic               v1_r, v2_r, v3_r;

  always_comb begin
    la = 33'(first_lat);
    lb = 33'(second_lat);
    if (la > hvd_pkg::LAT_LIM) la = hvd_pkg::LAT_LIM;
    else if (la < -hvd_pkg::LAT_LIM) la = -hvd_pkg::LAT_LIM;
    if (lb > hvd_pkg::LAT_LIM) lb = hvd_pkg::LAT_LIM;
    else if (lb < -hvd_pkg::LAT_LIM) lb = -hvd_pkg::LAT_LIM;
    dlat = lb - la;

    // fold the longitude difference into [0, 180] degrees
    diff = 33'(second_lon) - 33'(first_lon);
    t1   = diff + hvd_pkg::SPAN;
    if (diff >= hvd_pkg::SPAN) dm = diff - hvd_pkg::SPAN;
    else if (diff < 0) dm = (t1 < 0) ? t1 + hvd_pkg::SPAN : t1;
    else dm = diff;
    if (dm > hvd_pkg::HALF_SPAN) dm = hvd_pkg::SPAN - dm;

    mag_nxt[0] = (dlat < 0) ? 30'(-dlat) : 30'(dlat);
    mag_nxt[1] = 30'(dm);
    mag_nxt[2] = (la < 0) ? 30'(-la) : 30'(la);
    mag_nxt[3] = (lb < 0) ? 30'(-lb) : 30'(lb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    // half angles for the two sine lanes, full angles for the cosine lanes
    localparam int SH = (l < 2) ? hvd_pkg::SH_HALF : hvd_pkg::SH_FULL;
    logic [61:0] rnd;

    assign rnd = ({1'b0, prod_r[l]} + (62'(1) << (SH - 1))) >> SH;

    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[l]  <= mag_nxt[l];
        prod_r[l] <= 61'(mag_r[l]) * 61'(hvd_pkg::DEG2RAD);
        ang_r[l]  <= (rnd > 62'(hvd_pkg::HALF_PI_Q30)) ? hvd_pkg::HALF_PI_Q30 : rnd[30:0];
      end
    end

    assign ang[l] = ang_r[l];
  end

  assign vld_out = v3_r;

endmodule

/* rtl/hvd_cordic.sv */
// Pipelined CORDIC, one iteration per stage, rotation or vectoring mode.
module hvd_cordic #(
  parameter int STEPS     = 24,
  parameter bit VECTORING = 1'b0,
  parameter int LANES     = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  hvd_pkg::cw_t  x_in [LANES],
  input  hvd_pkg::cw_t  y_in [LANES],
  input  hvd_pkg::cw_t  z_in [LANES],
  output logic          vld_out,
  output hvd_pkg::cw_t  x_out [LANES],
  output hvd_pkg::cw_t  y_out [LANES],
  output hvd_pkg::cw_t  z_out [LANES]
);

  hvd_pkg::cw_t xs [LANES][STEPS+1];
  hvd_pkg::cw_t ys [LANES][STEPS+1];
  hvd_pkg::cw_t zs [LANES][STEPS+1];
  logic         vs [STEPS+1];

  assign vs[0] = vld_in;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [4:0]   K   = 5'(i);
    localparam hvd_pkg::cw_t ARC = hvd_pkg::arc(K);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      hvd_pkg::cw_t dx, dy;
      logic         fwd, bwd;

      // x moves by y shifted, y moves by x shifted
      assign dx  = ys[l][i] >>> K;
      assign dy  = xs[l][i] >>> K;
      // fwd: x - dx, y + dy, z - arc; bwd: the reverse; neither on a zero residual
      assign fwd = VECTORING ? (ys[l][i] < 0) : (zs[l][i] > 0);
      assign bwd = VECTORING ? (ys[l][i] > 0) : (zs[l][i] < 0);

      always_ff @(posedge clk) begin
        if (en) begin
          if (fwd) begin
            xs[l][i+1] <= xs[l][i] - dx;
            ys[l][i+1] <= ys[l][i] + dy;
            zs[l][i+1] <= zs[l][i] - ARC;
          end else if (bwd) begin
            xs[l][i+1] <= xs[l][i] + dx;
            ys[l][i+1] <= ys[l][i] - dy;
            zs[l][i+1] <= zs[l][i] + ARC;
          end else begin
            xs[l][i+1] <= xs[l][i];
            ys[l][i+1] <= ys[l][i];
            zs[l][i+1] <= zs[l][i];
          end
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_io
    assign xs[l][0] = x_in[l];
    assign ys[l][0] = y_in[l];
    assign zs[l][0] = z_in[l];
    assign x_out[l] = xs[l][STEPS];
    assign y_out[l] = ys[l][STEPS];
    assign z_out[l] = zs[l][STEPS];
  end

  assign vld_out = vs[STEPS];

endmodule

/* rtl/hvd_isqrt.sv */
// Pipelined digit-by-digit floor square root, one result bit per stage.
module hvd_isqrt #(
  parameter int LANES = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_in,
  input  hvd_pkg::sq_t   v_in [LANES],
  output logic           vld_out,
  output hvd_pkg::q30_t  root [LANES]
);

  localparam int N = hvd_pkg::SQRT_STEPS;

  hvd_pkg::sq_t vs [LANES][N+1];
  hvd_pkg::sq_t rs [LANES][N+1];
  logic         vv [N+1];

  assign vv[0] = vld_in;

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam hvd_pkg::sq_t BIT = 64'(1) << (62 - 2 * i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vv[i+1] <= 1'b0;
      end else if (en) begin
        vv[i+1] <= vv[i];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      hvd_pkg::sq_t trial;

      assign trial = rs[l][i] + BIT;

      always_ff @(posedge clk) begin
        if (en) begin
          if (vs[l][i] >= trial) begin
            vs[l][i+1] <= vs[l][i] - trial;
            rs[l][i+1] <= (rs[l][i] >> 1) + BIT;
          end else begin
            vs[l][i+1] <= vs[l][i];
            rs[l][i+1] <= rs[l][i] >> 1;
          end
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_io
    assign vs[l][0] = v_in[l];
    assign rs[l][0] = '0;
    assign root[l]  = rs[l][N][30:0];
  end

  assign vld_out = vv[N];

endmodule

/* rtl/hvd_scale.sv */
// Back end: angle to distance, divide by 125 via reciprocal, road product, near test.
module hvd_scale (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  hvd_pkg::cw_t  z_in,
  input  logic [22:0]   radius,
  input  logic [9:0]    factor,
  input  logic [24:0]   thr,
  output logic          vld_out,
  output logic [24:0]   distance,
  output logic [34:0]   road_prod,
  output logic          near
);

  hvd_pkg::q30_t zc;
  logic [53:0]   prod_r;
  logic [54:0]   nsum;
  logic [31:0]   n;
  logic [31:0]   n2_r, n3_r;
  logic [48:0]   ph_r, pl_r;
  logic [65:0]   tot;
  logic [26:0]   qe_r;
  logic [33:0]   rem;
  logic [26:0]   qc;
  logic [24:0]   dist4_r, dist5_r;
  logic [34:0]   rp_r;
  logic          near_r;
  logic          v1_r, v2_r, v3_r, v4_r, v5_r;

  always_comb begin
    if (z_in < 0) zc = '0;
    else if (z_in > hvd_pkg::HALF_PI_S) zc = hvd_pkg::HALF_PI_Q30;
    else zc = z_in[30:0];

    nsum = {1'b0, prod_r} + hvd_pkg::DIST_ROUND;
    n    = nsum[hvd_pkg::DIST_SHIFT +: 32];

    tot  = (66'(ph_r) << 16) + 66'(pl_r);

    // estimate is low by at most one; fix with one compare
    rem  = 34'(n3_r) - 34'(qe_r) * 34'(125);
    qc   = (rem >= 34'(125)) ? qe_r + 27'(1) : qe_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= 54'(radius) * 54'(zc);
      n2_r    <= n;
      ph_r    <= 49'(n[31:16]) * 49'(hvd_pkg::DIV125_M);
      pl_r    <= 49'(n[15:0]) * 49'(hvd_pkg::DIV125_M);
      n3_r    <= n2_r;
      qe_r    <= tot[hvd_pkg::DIV_SHIFT +: 27];
      dist4_r <= (qc > 27'(hvd_pkg::DIST_MAX)) ? hvd_pkg::DIST_MAX : qc[24:0];
      dist5_r <= dist4_r;
      rp_r    <= 35'(dist4_r) * 35'(factor);
      near_r  <= dist4_r < thr;
    end
  end

  assign vld_out   = v5_r;
  assign distance  = dist5_r;
  assign road_prod = rp_r;
  assign near      = near_r;

endmodule

/* rtl/haversine_distance.sv */
// Top level of the pipelined haversine great-circle distance unit.
//
// Input channel in_*: one transfer carries two positions (lat/lon in degrees
// times 2^22); the unit gives exactly one result transfer on out_* per input.
// The config channel cfg_* is always ready and writes sphere radius, road
// factor and near threshold; write it only while no item is in flight.
// From input to output an item passes 3 front stages, a rotation CORDIC of
// CORDIC_STEPS stages, 3 product stages, a 32-stage square root, a vectoring
// CORDIC of CORDIC_STEPS stages, 5 scaling stages and the output register.
// Throughput is one item per cycle while out_tready stays high.
// When the receiver stalls with a result in the output register, the whole
// pipeline holds and in_tready drops; nothing is dropped or repeated.
// Reset clears every stage valid and loads the default register values.
`include "assert_macros.svh"

module haversine_distance #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // first_lat[29:0], first_lon[60:30], second_lat[90:61], second_lon[121:91]
  input  logic [127:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // straight_distance[24:0], road_distance[51:25], is_near[52]
  output logic [55:0]   out_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [24:0]   cfg_data
);

  logic          en;
  logic [22:0]   radius_r;
  logic [9:0]    factor_r;
  logic [24:0]   thr_r;

  logic          fv;
  hvd_pkg::q30_t ang [4];
  hvd_pkg::cw_t  rx_in [4], ry_in [4], rz_in [4];
  hvd_pkg::cw_t  rx [4], ry [4], rz [4];
  logic          rv;

  hvd_pkg::q30_t s_lat, s_lon, cos_a, cos_b, p, q;
  logic [61:0]   pa_r, pb_r, ss_r, ss2_r, pq_r;
  logic [62:0]   hsum;
  hvd_pkg::sq_t  hav, sq_in [2], sq_in_r [2];
  logic          h1_r, h2_r, h3_r;

  logic          qv;
  hvd_pkg::q30_t rt [2];
  hvd_pkg::cw_t  vx_in [1], vy_in [1], vz_in [1];
  hvd_pkg::cw_t  vx [1], vy [1], vz [1];
  logic          vv;

  logic          sv;
  logic [24:0]   s_dist;
  logic [34:0]   s_rp;
  logic          s_near;
  logic [27:0]   road_rnd;

  logic          out_tvalid_r;
  logic [24:0]   dist_r;
  logic [26:0]   road_r;
  logic          near_r;

  // the whole pipeline advances unless a finished result is held back
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 23'd6371000;
      factor_r <= 10'd614;
      thr_r    <= 25'd2560;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hvd_pkg::REG_RADIUS: radius_r <= cfg_data[22:0];
        hvd_pkg::REG_ROAD:   factor_r <= cfg_data[9:0];
        hvd_pkg::REG_NEAR:   thr_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  hvd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vld_in     (in_tvalid && in_tready),
    .first_lat  ($signed(in_tdata[29:0])),
    .first_lon  ($signed(in_tdata[60:30])),
    .second_lat ($signed(in_tdata[90:61])),
    .second_lon ($signed(in_tdata[121:91])),
    .vld_out    (fv),
    .ang        (ang)
  );

  // lanes: half dlat (sin), half dlon (sin), lat a (cos), lat b (cos)
  for (genvar l = 0; l < 4; l++) begin : g_rot_in
    assign rx_in[l] = hvd_pkg::GAIN_INV;
    assign ry_in[l] = '0;
    assign rz_in[l] = $signed({3'b000, ang[l]});
  end

  hvd_cordic #(
    .STEPS     (CORDIC_STEPS),
    .VECTORING (1'b0),
    .LANES     (4)
  ) u_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (fv),
    .x_in    (rx_in),
    .y_in    (ry_in),
    .z_in    (rz_in),
    .vld_out (rv),
    .x_out   (rx),
    .y_out   (ry),
    .z_out   (rz)
  );

  always_comb begin
    s_lat = hvd_pkg::clamp_q30(ry[0]);
    s_lon = hvd_pkg::clamp_q30(ry[1]);
    cos_a = hvd_pkg::clamp_q30(rx[2]);
    cos_b = hvd_pkg::clamp_q30(rx[3]);
    p     = 31'((pa_r + (62'(1) << 29)) >> 30);
    q     = 31'((pb_r + (62'(1) << 29)) >> 30);
    hsum  = 63'(ss2_r) + 63'(pq_r);
    hav   = (hsum > (63'(1) << 60)) ? (64'(1) << 60) : 64'(hsum);
    sq_in[0] = hav;
    sq_in[1] = (64'(1) << 60) - hav;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r <= 1'b0;
      h2_r <= 1'b0;
      h3_r <= 1'b0;
    end else if (en) begin
      h1_r <= rv;
      h2_r <= h1_r;
      h3_r <= h2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r       <= 62'(cos_a) * 62'(s_lon);
      pb_r       <= 62'(cos_b) * 62'(s_lon);
      ss_r       <= 62'(s_lat) * 62'(s_lat);
      pq_r       <= 62'(p) * 62'(q);
      ss2_r      <= ss_r;
      sq_in_r[0] <= sq_in[0];
      sq_in_r[1] <= sq_in[1];
    end
  end

  hvd_isqrt #(
    .LANES (2)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (h3_r),
    .v_in    (sq_in_r),
    .vld_out (qv),
    .root    (rt)
  );

  assign vx_in[0] = $signed({3'b000, rt[1]});
  assign vy_in[0] = $signed({3'b000, rt[0]});
  assign vz_in[0] = '0;

  hvd_cordic #(
    .STEPS     (CORDIC_STEPS),
    .VECTORING (1'b1),
    .LANES     (1)
  ) u_vec (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (qv),
    .x_in    (vx_in),
    .y_in    (vy_in),
    .z_in    (vz_in),
    .vld_out (vv),
    .x_out   (vx),
    .y_out   (vy),
    .z_out   (vz)
  );

  hvd_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_in    (vv),
    .z_in      (vz[0]),
    .radius    (radius_r),
    .factor    (factor_r),
    .thr       (thr_r),
    .vld_out   (sv),
    .distance  (s_dist),
    .road_prod (s_rp),
    .near      (s_near)
  );

  assign road_rnd = 28'((36'(s_rp) + 36'(128)) >> 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= s_dist;
      road_r <= (road_rnd > 28'(hvd_pkg::ROAD_MAX)) ? hvd_pkg::ROAD_MAX : road_rnd[26:0];
      near_r <= s_near;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, near_r, road_r, dist_r};

  `HVD_ASSERT_IMPL(a_near_matches, out_tvalid_r, near_r == (dist_r < thr_r))
  `HVD_ASSERT_IMPL(a_road_not_below, out_tvalid_r && (factor_r >= 10'd256), road_r >= 27'(dist_r))
  `HVD_ASSERT_IMPL(a_stall_blocks_input, out_tvalid_r && !out_tready, !in_tready)
  `HVD_ASSERT_NEXT(a_out_from_scale, en && sv, out_tvalid_r)

endmodule

/* verif/haversine_distance_tb.sv */
// Self-checking testbench for the haversine great-circle distance unit.
module haversine_distance_tb;

  localparam longint DEG      = 64'sd1 << 22;
  localparam int     LAT_SPAN = 377487360;
  localparam int     LON_SPAN = 754974720;
  localparam int     DRAIN    = 140;

  typedef struct packed {
    logic [24:0] distance;
    logic [26:0] road;
    logic        is_near;
  } trip_t;

  localparam longint ATAN_TAB [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam int     STEPS   = 24;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [127:0]      in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [55:0]       out_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  hvd_pkg::reg_idx_t cfg_index = hvd_pkg::REG_RADIUS;
  logic [24:0]       cfg_data = '0;

  logic [63:0] radius_m = 64'd6371000;
  logic [63:0] road_q8 = 64'd614;
  logic [63:0] near_lim = 64'd2560;

  trip_t pending_trips[$];
  int    errors = 0;
  int    gap_left = 0;

  haversine_distance dut (.*);

  always #5 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic logic [63:0] clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > ONE_Q30) return ONE_Q30;
    return v;
  endfunction

  function automatic logic [63:0] to_radians(logic [63:0] mag, int extra);
    int sh;
    sh = 28 + extra;
    return (mag * 64'd1199381129 + (64'd1 << (sh - 1))) >> sh;
  endfunction

  task automatic rotate(input logic [63:0] ang, output logic [63:0] c, output logic [63:0] s);
    longint x, y, z, dx, dy;
    x = 64'sd652032874;
    y = 0;
    if (ang > HALF_PI) ang = HALF_PI;
    z = ang;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z > 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else if (z < 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    c = clamp_unit(x);
    s = clamp_unit(y);
  endtask

  function automatic logic [63:0] arc_angle(logic [63:0] xin, logic [63:0] yin);
    longint x, y, z, dx, dy;
    x = xin;
    y = yin;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else if (y < 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    if (z < 0) z = 0;
    if (z > HALF_PI) z = HALF_PI;
    return z;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip_lat(longint v);
    if (v > 90 * DEG) return 90 * DEG;
    if (v < -90 * DEG) return -90 * DEG;
    return v;
  endfunction

  function automatic logic [63:0] absval(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic predict_trip(input logic [29:0] la1, input logic [30:0] lo1,
                              input logic [29:0] la2, input logic [30:0] lo2,
                              output trip_t t);
    longint lat_a, lat_b, lon_a, lon_b, dl;
    logic [63:0] s_lat, s_lon, cos_a, cos_b, unused, p, q, hav, z, distance, road;
    lat_a = clip_lat(longint'($signed(la1)));
    lat_b = clip_lat(longint'($signed(la2)));
    lon_a = longint'($signed(lo1));
    lon_b = longint'($signed(lo2));
    dl = (lon_b - lon_a) % (360 * DEG);
    if (dl < 0) dl += 360 * DEG;
    if (dl > 180 * DEG) dl = 360 * DEG - dl;
    rotate(to_radians(absval(lat_b - lat_a), 1), unused, s_lat);
    rotate(to_radians(dl, 1), unused, s_lon);
    rotate(to_radians(absval(lat_a), 0), cos_a, unused);
    rotate(to_radians(absval(lat_b), 0), cos_b, unused);
    p = (cos_a * s_lon + (64'd1 << 29)) >> 30;
    q = (cos_b * s_lon + (64'd1 << 29)) >> 30;
    hav = s_lat * s_lat + p * q;
    if (hav > (64'd1 << 60)) hav = 64'd1 << 60;
    z = arc_angle(floor_root((64'd1 << 60) - hav), floor_root(hav));
    distance = (radius_m * z + 64'd262144000) / 64'd524288000;
    if (distance > 64'd33554431) distance = 64'd33554431;
    road = (distance * road_q8 + 64'd128) >> 8;
    if (road > 64'd134217727) road = 64'd134217727;
    t.distance = distance[24:0];
    t.road = road[26:0];
    t.is_near = (distance < near_lim);
  endtask

  // ---------------- drivers ----------------
  task automatic send_trip(input logic [29:0] la1, input logic [30:0] lo1,
                           input logic [29:0] la2, input logic [30:0] lo2);
    trip_t t;
    if (gap_left == 0) begin
      // new burst: maybe idle first
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      gap_left = $urandom_range(1, 20);
    end
    gap_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, lo2, la2, lo1, la1};
    do @(posedge clk); while (!in_tready);
    predict_trip(la1, lo1, la2, lo2, t);
    pending_trips.push_back(t);
    @(negedge clk);
  endtask

  task automatic drain_all();
    in_tvalid <= 1'b0;
    while (pending_trips.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(input hvd_pkg::reg_idx_t idx, input logic [24:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hvd_pkg::REG_RADIUS: radius_m = val[22:0];
      hvd_pkg::REG_ROAD:   road_q8 = val[9:0];
      hvd_pkg::REG_NEAR:   near_lim = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [29:0] pick_lat();
    return 30'(int'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN);
  endfunction

  function automatic logic [30:0] pick_lon();
    return 31'(longint'($urandom_range(0, 2 * LON_SPAN)) - LON_SPAN);
  endfunction

  task automatic send_random();
    logic [29:0] la1, la2;
    logic [30:0] lo1, lo2;
    int pick;
    pick = $urandom_range(0, 9);
    la1 = pick_lat();
    lo1 = pick_lon();
    la2 = pick_lat();
    lo2 = pick_lon();
    if (pick >= 6 && pick <= 7) begin
      // nearby points to exercise the near flag around the threshold
      la2 = la1 + 30'(int'($urandom_range(0, 200000)) - 100000);
      lo2 = lo1 + 31'(int'($urandom_range(0, 200000)) - 100000);
    end else if (pick == 8) begin
      la1 = 30'($urandom); lo1 = 31'($urandom); la2 = 30'($urandom); lo2 = 31'($urandom);
    end else if (pick == 9) begin
      la1 = $urandom_range(0, 1) ? 30'h1FFFFFFF : 30'h20000000;
      lo2 = $urandom_range(0, 1) ? 31'h3FFFFFFF : 31'h40000000;
    end
    send_trip(la1, lo1, la2, lo2);
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    send_trip('0, '0, '0, '0);                                      // identical points
    send_trip(30'(90 * DEG), '0, 30'(-90 * DEG), '0);                 // pole to pole
    send_trip('0, '0, '0, 31'(180 * DEG));                          // antipodal on equator
    send_trip(30'h1FFFFFFF, '0, 30'h20000000, '0);                  // latitudes clamped
    send_trip(30'(45 * DEG), 31'h3FFFFFFF, 30'(45 * DEG), 31'h40000000);
    send_trip('0, 31'(-179 * DEG), '0, 31'(179 * DEG));              // wrap across the date line
    send_trip('0, 31'(LON_SPAN), '0, 31'(-LON_SPAN));
    send_trip(30'(LAT_SPAN), 31'(LON_SPAN), 30'(-LAT_SPAN), 31'(-LON_SPAN));
    send_trip(30'(30 * DEG), 31'(78 * DEG), 30'(30 * DEG + 1000), 31'(78 * DEG + 1000));
    send_trip(30'(30 * DEG), 31'(78 * DEG), 30'(30 * DEG), 31'(78 * DEG + 1));
    send_trip('1, 31'h7FFFFFFF, '1, 31'h7FFFFFFF);
    send_trip(30'h15555555, 31'h2AAAAAAA, 30'h2AAAAAAA, 31'h55555555);
    send_trip(30'(-60 * DEG), 31'(10 * DEG), 30'(60 * DEG), 31'(-170 * DEG));
  endtask

  task automatic test_random(input int n);
    repeat (n) send_random();
  endtask

  task automatic test_config_extremes();
    drain_all();
    write_reg(hvd_pkg::REG_RADIUS, 25'd6300000);
    write_reg(hvd_pkg::REG_ROAD, 25'd256);
    write_reg(hvd_pkg::REG_NEAR, 25'd0);
    test_directed();
    test_random(130);
    drain_all();
    write_reg(hvd_pkg::REG_RADIUS, 25'd6400000);
    write_reg(hvd_pkg::REG_ROAD, 25'd1023);
    write_reg(hvd_pkg::REG_NEAR, 25'd20971519);
    test_random(130);
    drain_all();
    // out-of-range index and wide values that get masked
    write_reg(hvd_pkg::reg_idx_t'(3), 25'h1FFFFFF);
    write_reg(hvd_pkg::REG_RADIUS, 25'h1FFFFFF);
    write_reg(hvd_pkg::REG_ROAD, 25'h1FFFFFF);
    write_reg(hvd_pkg::REG_NEAR, 25'd100000);
    test_random(100);
    drain_all();
    write_reg(hvd_pkg::REG_RADIUS, 25'($urandom_range(6300000, 6400000)));
    write_reg(hvd_pkg::REG_ROAD, 25'($urandom_range(256, 1023)));
    write_reg(hvd_pkg::REG_NEAR, 25'($urandom_range(0, 400000)));
    test_random(100);
  endtask

  // ---------------- receiver and checker ----------------
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 63) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    trip_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.distance = out_tdata[24:0];
      got.road = out_tdata[51:25];
      got.is_near = out_tdata[52];
      if (pending_trips.size() == 0) begin
        $display("%0t: unexpected result transfer, got %h", $time, out_tdata);
        errors++;
      end else begin
        want = pending_trips.pop_front();
        if (got.distance !== want.distance) begin
          $display("%0t: distance expected %0d actual %0d", $time, want.distance,
                   got.distance);
          errors++;
        end
        if (got.road !== want.road) begin
          $display("%0t: road expected %0d actual %0d", $time, want.road, got.road);
          errors++;
        end
        if (got.is_near !== want.is_near) begin
          $display("%0t: near flag expected %0d actual %0d", $time, want.is_near, got.is_near);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(150);
    test_config_extremes();
    drain_all();
    if (errors == 0) begin
      $display("haversine_distance test passed");
    end else begin
      $display("haversine_distance test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("haversine_distance test failed");
    $finish;
  end

endmodule

/* haversine_distance.f */
+incdir+rtl
rtl/hvd_pkg.sv
rtl/hvd_front.sv
rtl/hvd_cordic.sv
rtl/hvd_isqrt.sv
rtl/hvd_scale.sv
rtl/haversine_distance.sv
verif/haversine_distance_tb.sv
